// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/erv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package erv_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int ITERS = 24;
	localparam int CW = FRAC_BITS + 2;
	localparam logic signed [33:0] GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

	typedef logic signed [33:0] cval_t;
	typedef logic signed [CW-1:0] coef_t;

	function automatic logic signed [33:0] atan_at(input int i);
		logic signed [33:0] t [ITERS];
		t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
			34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
			34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
			34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
			34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
			34'sd652, 34'sd326, 34'sd163, 34'sd81};
		return t[i];
	endfunction

	function automatic coef_t clamp_unit(input logic signed [47:0] v);
		if (v > 48'(ONE))
			return ONE;
		if (v < -48'(ONE))
			return -ONE;
		return CW'(v);
	endfunction

	function automatic logic signed [47:0] rnd_mul(input coef_t a, input coef_t b);
		logic signed [2*CW-1:0] p;
		p = a * b + (2*CW)'(1 <<< (FRAC_BITS - 1));
		return 48'(p >>> FRAC_BITS);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/erv_cordic_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One sine/cosine lane: quadrant fold, pipelined CORDIC, unfold and round.
module erv_cordic_lane (
	input  wire logic clk,
	input  wire logic [erv_pkg::ANGLE_BITS-1:0] angle,
	output erv_pkg::coef_t sin_o,
	output erv_pkg::coef_t cos_o
);
	localparam int N = erv_pkg::ITERS;
	erv_pkg::cval_t x_s [N+1];
	erv_pkg::cval_t y_s [N+1];
	erv_pkg::cval_t z_s [N+1];
	logic [1:0] q_s [N+1];
	logic [31:0] phase, rem;
	logic [1:0] q;
	logic signed [33:0] xr, yr;

	assign phase = {angle, (32 - erv_pkg::ANGLE_BITS)'(0)};
	assign q = 2'((phase + 32'h2000_0000) >> 30);
	assign rem = phase - {q, 30'd0};

	always_ff @(posedge clk) begin
		x_s[0] <= erv_pkg::GAIN;
		y_s[0] <= '0;
		z_s[0] <= 34'($signed(rem));
		q_s[0] <= q;
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			q_s[i+1] <= q_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - erv_pkg::atan_at(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + erv_pkg::atan_at(i);
			end
		end
	end

	always_comb begin
		unique case (q_s[N])
			2'd1: begin xr = -y_s[N]; yr = x_s[N]; end
			2'd2: begin xr = -x_s[N]; yr = -y_s[N]; end
			2'd3: begin xr = y_s[N]; yr = -x_s[N]; end
			default: begin xr = x_s[N]; yr = y_s[N]; end
		endcase
	end

	localparam int SH = 30 - erv_pkg::FRAC_BITS;
	always_ff @(posedge clk) begin
		cos_o <= erv_pkg::clamp_unit(48'((xr + 34'(1 <<< (SH - 1))) >>> SH));
		sin_o <= erv_pkg::clamp_unit(48'((yr + 34'(1 <<< (SH - 1))) >>> SH));
	end
endmodule
`default_nettype wire

// ===== rtl/erv_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Matrix build and dot products over four registered stages.
module erv_merge (
	input  wire logic clk,
	input  wire erv_pkg::coef_t sp, cp, sy, cy, sr, cr,
	input  wire logic signed [31:0] vx, vy, vz,
	output logic signed [31:0] rx, ry, rz
);
	erv_pkg::coef_t sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	erv_pkg::coef_t crcy_s1, crsy_s1, srcy_s1, srsy_s1;
	logic signed [31:0] v_s1 [3], v_s2 [3];
	erv_pkg::coef_t m_s2 [9];
	logic signed [32+erv_pkg::CW-1:0] p_s3 [9];

	always_ff @(posedge clk) begin
		sp_s1 <= sp; cp_s1 <= cp; sy_s1 <= sy; cy_s1 <= cy; sr_s1 <= sr; cr_s1 <= cr;
		crcy_s1 <= erv_pkg::CW'(erv_pkg::rnd_mul(cr, cy));
		crsy_s1 <= erv_pkg::CW'(erv_pkg::rnd_mul(cr, sy));
		srcy_s1 <= erv_pkg::CW'(erv_pkg::rnd_mul(sr, cy));
		srsy_s1 <= erv_pkg::CW'(erv_pkg::rnd_mul(sr, sy));
		v_s1 <= '{vx, vy, vz};
	end

	always_ff @(posedge clk) begin
		m_s2[0] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(cp_s1, cy_s1));
		m_s2[1] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(sp_s1, srcy_s1) - 48'(crsy_s1));
		m_s2[2] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(sp_s1, crcy_s1) + 48'(srsy_s1));
		m_s2[3] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(cp_s1, sy_s1));
		m_s2[4] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(sp_s1, srsy_s1) + 48'(crcy_s1));
		m_s2[5] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(sp_s1, crsy_s1) - 48'(srcy_s1));
		m_s2[6] <= erv_pkg::clamp_unit(-48'(sp_s1));
		m_s2[7] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(sr_s1, cp_s1));
		m_s2[8] <= erv_pkg::clamp_unit(erv_pkg::rnd_mul(cr_s1, cp_s1));
		v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++)
			p_s3[i] <= v_s2[i % 3] * m_s2[i];
	end

	function automatic logic signed [31:0] sat_row(input logic signed [63:0] a);
		logic signed [63:0] r;
		r = (a + 64'(1 <<< (erv_pkg::FRAC_BITS - 1))) >>> erv_pkg::FRAC_BITS;
		if (r > 64'sd2147483647)
			return 32'sh7fffffff;
		if (r < -64'sd2147483648)
			return 32'sh80000000;
		return 32'(r);
	endfunction

	always_ff @(posedge clk) begin
		rx <= sat_row(64'(p_s3[0]) + 64'(p_s3[1]) + 64'(p_s3[2]));
		ry <= sat_row(64'(p_s3[3]) + 64'(p_s3[4]) + 64'(p_s3[5]));
		rz <= sat_row(64'(p_s3[6]) + 64'(p_s3[7]) + 64'(p_s3[8]));
	end
endmodule
`default_nettype wire

// ===== rtl/euler_rotate_vector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Euler-angle vector rotation unit.
// Input channel: raise start with pitch, yaw, roll and vec_x/y/z; the item
// is taken on any edge where start is high and busy is low. busy is always
// low, so one item may enter every cycle.
// Output channel: rot_x/y/z carry one item for one cycle while done is high.
// The receiver cannot stall; results are not held.
// Pipeline: 26 stages in the three parallel CORDIC lanes (fold, 24
// micro-rotations, round; the fold stage loads at the accepting edge),
// then 4 for matrix build, products and row sums.
// Throughput: one item per cycle.
// Reset clears the valid pipeline only; items in flight are dropped.
module euler_rotate_vector_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic signed [15:0] pitch,
	input  wire logic signed [15:0] yaw,
	input  wire logic signed [15:0] roll,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	output logic done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);
`include "assert_macros.svh"
	localparam int LAT = erv_pkg::ITERS + 6;
	localparam int VD = erv_pkg::ITERS + 2;
	erv_pkg::coef_t sp, cp, sy, cy, sr, cr;
	logic [LAT-1:0] vld_q;
	logic signed [31:0] vx_q [VD], vy_q [VD], vz_q [VD];

	assign busy = 1'b0;

	erv_cordic_lane u_p (.clk(clk), .angle(pitch), .sin_o(sp), .cos_o(cp));
	erv_cordic_lane u_y (.clk(clk), .angle(yaw), .sin_o(sy), .cos_o(cy));
	erv_cordic_lane u_r (.clk(clk), .angle(roll), .sin_o(sr), .cos_o(cr));

	always_ff @(posedge clk) begin
		vx_q[0] <= vec_x; vy_q[0] <= vec_y; vz_q[0] <= vec_z;
		for (int i = 1; i < VD; i++) begin
			vx_q[i] <= vx_q[i-1]; vy_q[i] <= vy_q[i-1]; vz_q[i] <= vz_q[i-1];
		end
	end

	erv_merge u_merge (
		.clk(clk), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
		.vx(vx_q[VD-1]), .vy(vy_q[VD-1]), .vz(vz_q[VD-1]),
		.rx(rot_x), .ry(rot_y), .rz(rot_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end
	assign done = vld_q[LAT-1];

	`ASSERT_NEXT(a_flow, clk, arst_n, start && !busy, vld_q[0])
	`ASSERT_IMPL(a_done, clk, arst_n, done == $past(vld_q[LAT-2]))
endmodule
`default_nettype wire
